// ===== hdl/qpc_pkg.sv =====
// Shared types and constants of the quadrature position counter.
package qpc_pkg;

  localparam int POS_W = 16;
  localparam int REV_W = 32;

  localparam logic [POS_W-1:0] CPR_RESET = 16'd468;

  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);
  localparam int CMD_CNT_W       = $clog2(CMD_QUEUE_DEPTH + 1);

  localparam int RES_QUEUE_DEPTH = 2;
  localparam int RES_PTR_W       = $clog2(RES_QUEUE_DEPTH);
  localparam int RES_CNT_W       = $clog2(RES_QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    logic  clear;
    step_t step;
    logic  step_error;
    logic  index_rise;
  } cmd_t;

  // Handshake between the command queue and the back.
  typedef struct packed {
    logic valid;
    cmd_t head;
  } cmd_head_t;

  typedef struct packed {
    logic [POS_W-1:0]        position;
    logic signed [REV_W-1:0] revolutions;
    logic                    home_valid;
    logic                    step_error;
  } result_t;

endpackage

// ===== hdl/quadrature_position_counter.sv =====
// Top level of the x4 quadrature position counter with index homing.
//
// This block takes one item per clock while in_full is low: either a sample
// of encoder channels A and B and the index level, or a clear command. The
// front compares each sample with the previous one and classifies it as a
// step up, a step down, no step, or a step error when both channels changed
// at once. A two-entry command queue carries the classified item to the
// back, which keeps the position modulo counts_per_rev, the signed turn
// count and the home position, and writes one result per item into a
// two-entry result buffer. A result shows on the out_ ports once its item
// has passed through the command queue and its result has been written
// into the result buffer; a full result buffer holds the item at the head
// of the command queue. With out_pop held high the block sustains one
// item per cycle; in_full rises only after the result buffer has filled
// and the command queue has backed up behind it. The first index rise
// after reset or a clear latches the position as home, and every later
// rise puts the position back to home after that sample's step. Write
// counts_per_rev only while no item is in flight.
module quadrature_position_counter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [qpc_pkg::POS_W-1:0]         cfg_wr_data,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_command,
  input  logic                              in_chan_a,
  input  logic                              in_chan_b,
  input  logic                              in_index_level,
  input  logic                              out_pop,
  output logic                              out_empty,
  output logic [qpc_pkg::POS_W-1:0]         out_position,
  output logic signed [qpc_pkg::REV_W-1:0]  out_revolutions,
  output logic                              out_home_valid,
  output logic                              out_step_error
);
  import qpc_pkg::*;

  cmd_t      cmd;
  cmd_head_t head;
  logic      accept;
  logic      cmd_pop;

  // An item is taken whenever the command queue has a free entry.
  assign accept = in_push && !in_full;

  qpc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_command     (in_command),
    .in_chan_a      (in_chan_a),
    .in_chan_b      (in_chan_b),
    .in_index_level (in_index_level),
    .cmd            (cmd)
  );

  qpc_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_cmd (cmd),
    .full     (in_full),
    .pop      (cmd_pop),
    .head     (head)
  );

  qpc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .head            (head),
    .cmd_pop         (cmd_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_position    (out_position),
    .out_revolutions (out_revolutions),
    .out_home_valid  (out_home_valid),
    .out_step_error  (out_step_error)
  );

endmodule

// ===== hdl/qpc_front.sv =====
// Front part: edge detection and x4 direction decoding of accepted items.
module qpc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          in_command,
  input  logic          in_chan_a,
  input  logic          in_chan_b,
  input  logic          in_index_level,
  output qpc_pkg::cmd_t cmd
);
  import qpc_pkg::*;

  logic last_a_r, last_a_nxt;
  logic last_b_r, last_b_nxt;
  logic last_index_r, last_index_nxt;
  logic a_edge, b_edge;

  assign a_edge = in_chan_a ^ last_a_r;
  assign b_edge = in_chan_b ^ last_b_r;

  always_comb begin
    cmd = '0;
    cmd.step = STEP_NONE;
    if (in_command) begin
      cmd.clear = 1'b1;
    end else begin
      if (a_edge && b_edge) begin
        cmd.step_error = 1'b1;
      end else if (a_edge) begin
        cmd.step = (in_chan_a == in_chan_b) ? STEP_DOWN : STEP_UP;
      end else if (b_edge) begin
        cmd.step = (in_chan_a != in_chan_b) ? STEP_DOWN : STEP_UP;
      end
      cmd.index_rise = in_index_level & ~last_index_r;
    end
  end

  // A clear command leaves the remembered pin levels alone.
  always_comb begin
    last_a_nxt     = last_a_r;
    last_b_nxt     = last_b_r;
    last_index_nxt = last_index_r;
    if (accept && !in_command) begin
      last_a_nxt     = in_chan_a;
      last_b_nxt     = in_chan_b;
      last_index_nxt = in_index_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_a_r     <= 1'b0;
      last_b_r     <= 1'b0;
      last_index_r <= 1'b0;
    end else begin
      last_a_r     <= last_a_nxt;
      last_b_r     <= last_b_nxt;
      last_index_r <= last_index_nxt;
    end
  end

endmodule

// ===== hdl/qpc_cmd_queue.sv =====
// Short queue of classified items between the front and the back.
module qpc_cmd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  qpc_pkg::cmd_t      push_cmd,
  output logic               full,
  input  logic               pop,
  output qpc_pkg::cmd_head_t head
);
  import qpc_pkg::*;

  cmd_t                 entry_r [CMD_QUEUE_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full       = (cnt_r == CMD_CNT_W'(CMD_QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.head  = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/qpc_back.sv =====
// Back part: position, turn and home update, and the result buffer.
module qpc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [qpc_pkg::POS_W-1:0]         cfg_wr_data,
  input  qpc_pkg::cmd_head_t                head,
  output logic                              cmd_pop,
  input  logic                              out_pop,
  output logic                              out_empty,
  output logic [qpc_pkg::POS_W-1:0]         out_position,
  output logic signed [qpc_pkg::REV_W-1:0]  out_revolutions,
  output logic                              out_home_valid,
  output logic                              out_step_error
);
  import qpc_pkg::*;

  logic [POS_W-1:0]        cpr_r;
  logic [POS_W-1:0]        count_r, count_nxt;
  logic signed [REV_W-1:0] turns_r, turns_nxt;
  logic                    seen_r, seen_nxt;
  logic [POS_W-1:0]        home_r, home_nxt;
  logic [POS_W-1:0]        top;
  logic [POS_W-1:0]        stepped;
  result_t                 res;

  result_t              buf_r [RES_QUEUE_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_out_pop;
  logic                 space;

  assign out_empty  = (cnt_r == '0);
  assign do_out_pop = out_pop && !out_empty;
  assign space      = (cnt_r != RES_CNT_W'(RES_QUEUE_DEPTH)) || do_out_pop;
  assign cmd_pop    = head.valid && space;

  // A modulus of zero wraps the top count to all ones.
  assign top = cpr_r - 1'b1;

  always_comb begin
    count_nxt = count_r;
    turns_nxt = turns_r;
    seen_nxt  = seen_r;
    home_nxt  = home_r;
    stepped   = count_r;
    if (head.head.clear) begin
      count_nxt = '0;
      turns_nxt = '0;
      seen_nxt  = 1'b0;
    end else begin
      case (head.head.step)
        STEP_UP: begin
          if (count_r >= top) begin
            stepped   = '0;
            turns_nxt = turns_r + 1'b1;
          end else begin
            stepped = count_r + 1'b1;
          end
        end
        STEP_DOWN: begin
          if (count_r == '0) begin
            stepped   = top;
            turns_nxt = turns_r - 1'b1;
          end else begin
            stepped = count_r - 1'b1;
          end
        end
        default: stepped = count_r;
      endcase
      count_nxt = stepped;
      if (head.head.index_rise) begin
        if (!seen_r) begin
          home_nxt = stepped;
          seen_nxt = 1'b1;
        end else begin
          count_nxt = home_r;
        end
      end
    end
  end

  always_comb begin
    res.position    = count_nxt;
    res.revolutions = turns_nxt;
    res.home_valid  = seen_nxt;
    res.step_error  = head.head.step_error && !head.head.clear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r   <= CPR_RESET;
      count_r <= '0;
      turns_r <= '0;
      seen_r  <= 1'b0;
      home_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        cpr_r <= cfg_wr_data;
      end
      if (cmd_pop) begin
        count_r <= count_nxt;
        turns_r <= turns_nxt;
        seen_r  <= seen_nxt;
        home_r  <= home_nxt;
      end
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (cmd_pop) begin
      wr_ptr_nxt = (wr_ptr_r == RES_PTR_W'(RES_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_out_pop) begin
      rd_ptr_nxt = (rd_ptr_r == RES_PTR_W'(RES_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (cmd_pop && !do_out_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_out_pop && !cmd_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  assign out_position    = buf_r[rd_ptr_r].position;
  assign out_revolutions = buf_r[rd_ptr_r].revolutions;
  assign out_home_valid  = buf_r[rd_ptr_r].home_valid;
  assign out_step_error  = buf_r[rd_ptr_r].step_error;

endmodule

// ===== hdl/qpc_checker.sv =====
// Port-level checker of the quadrature position counter, with its bind.
module qpc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_full,
  input logic                              out_pop,
  input logic                              out_empty,
  input logic [qpc_pkg::POS_W-1:0]         out_position,
  input logic signed [qpc_pkg::REV_W-1:0]  out_revolutions,
  input logic                              out_home_valid
);
  import qpc_pkg::*;

  // Reset leaves both sides empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // The input side backs up only behind a result that waits to be taken.
  a_full_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input full while no result waits");

  // A waiting result that is not taken stays on the ports unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=>
      !out_empty && $stable(out_position) && $stable(out_revolutions) &&
      $stable(out_home_valid))
    else $error("waiting result changed before it was taken");

endmodule

bind quadrature_position_counter qpc_checker u_qpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_pop         (out_pop),
  .out_empty       (out_empty),
  .out_position    (out_position),
  .out_revolutions (out_revolutions),
  .out_home_valid  (out_home_valid)
);
